@@ rtl/mkd_pkg.sv @@
package mkd_pkg;

  // Symbol event codes on the result word
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_DOT  = 2'd1;
  localparam logic [1:0] EV_DASH = 2'd2;

  // Register map, by word index
  localparam logic [1:0] REG_DOT_MIN = 2'd0;
  localparam logic [1:0] REG_DASH    = 2'd1;
  localparam logic [1:0] REG_GAP     = 2'd2;

  localparam logic [15:0] DOT_MIN_RESET = 16'd1875;
  localparam logic [15:0] DASH_RESET    = 16'd12500;
  localparam logic [15:0] GAP_RESET     = 16'd25000;

  // Character assembly
  localparam int unsigned MAX_SYMBOLS = 5;
  localparam logic [2:0] SYM_MAX      = 3'(MAX_SYMBOLS);
  localparam logic [2:0] SYM_SAT      = 3'(MAX_SYMBOLS + 1);
  localparam logic [3:0] W_DOT        = 4'd7;
  localparam logic [3:0] W_DASH       = 4'd10;
  localparam int unsigned NUM_CHARS   = 13;

  // Weighted sums of A,B,C,D,S,E,N,T,1,2,3,4,5
  localparam logic [7:0] CODE_SUMS [NUM_CHARS] = '{
    8'd27, 8'd73, 8'd82, 8'd45, 8'd42, 8'd7, 8'd24, 8'd10,
    8'd147, 8'd141, 8'd132, 8'd120, 8'd105
  };

  // Depth of the queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  // Classified tick, passed from front to back
  typedef struct packed {
    logic dot;
    logic dash;
    logic gap;
  } mkd_evt_t;

  typedef struct packed {
    logic       found;
    logic [3:0] code;
  } mkd_match_t;

  // Look up a weighted sum; first match wins
  function automatic mkd_match_t mkd_lookup(input logic [7:0] sum);
    mkd_match_t m;
    m.found = 1'b0;
    m.code  = 4'd0;
    for (int i = 0; i < NUM_CHARS; i++) begin
      if (!m.found && CODE_SUMS[i] == sum) begin
        m.found = 1'b1;
        m.code  = 4'(i);
      end
    end
    return m;
  endfunction

endpackage

@@ rtl/mkd_if.sv @@
// Key sample channel
interface mkd_in_if;
  logic valid;
  logic ready;
  logic key_down;

  modport source(output valid, output key_down, input ready);
  modport sink(input valid, input key_down, output ready);
endinterface

// Decoded result channel
interface mkd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] symbol_event;
  logic       char_valid;
  logic [3:0] char_code;
  logic       char_invalid;

  modport source(output valid, output symbol_event, output char_valid,
                 output char_code, output char_invalid, input ready);
  modport sink(input valid, input symbol_event, input char_valid,
               input char_code, input char_invalid, output ready);
endinterface

@@ rtl/mkd_front.sv @@
module mkd_front import mkd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  mkd_in_if.sink        in_ch,
  input  logic [15:0]   dot_min_ticks,
  input  logic [15:0]   dash_ticks,
  input  logic [15:0]   gap_ticks,
  input  logic          q_full,
  output logic          q_push,
  output mkd_evt_t      q_data
);

  localparam int unsigned CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                  key_state_r, key_state_nxt;
  logic [COUNT_BITS-1:0] tick_r, tick_nxt;
  logic [COUNT_BITS-1:0] held_r, held_nxt;
  logic                  dash_rep_r, dash_rep_nxt;
  logic [COUNT_BITS-1:0] held_edge;
  logic [COUNT_BITS-1:0] tick_edge;
  logic                  dash_edge;
  logic                  dot_hit, dash_hit, gap_hit;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  // Restart the counter on a key edge, else count up and saturate
  always_comb begin
    key_state_nxt = in_ch.key_down;
    if (in_ch.key_down != key_state_r) begin
      held_edge = key_state_r ? tick_r : '0;
      tick_edge = '0;
      dash_edge = 1'b0;
    end else begin
      held_edge = held_r;
      tick_edge = (tick_r == CNT_MAX) ? tick_r : tick_r + 1'b1;
      dash_edge = dash_rep_r;
    end
  end

  // Classify the tick: dot on release, dash once per press, gap ends character
  always_comb begin
    dot_hit  = (CMP_W'(held_edge) > CMP_W'(dot_min_ticks)) &&
               (CMP_W'(held_edge) < CMP_W'(dash_ticks)) && (tick_edge != CNT_MAX);
    dash_hit = key_state_nxt && (CMP_W'(tick_edge) >= CMP_W'(dash_ticks)) &&
               !(dash_edge && !dot_hit);
    gap_hit  = !key_state_nxt && (CMP_W'(tick_edge) >= CMP_W'(gap_ticks));

    tick_nxt     = tick_edge;
    held_nxt     = dot_hit ? '0 : held_edge;
    dash_rep_nxt = dot_hit ? 1'b0 : dash_edge;
    if (dash_hit) begin
      dash_rep_nxt = 1'b1;
    end
    if (gap_hit) begin
      dash_rep_nxt = 1'b0;
    end

    q_data.dot  = dot_hit;
    q_data.dash = dash_hit;
    q_data.gap  = gap_hit;
  end

  // Advance timing state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_state_r <= 1'b0;
      tick_r      <= '0;
      held_r      <= '0;
      dash_rep_r  <= 1'b0;
    end else if (q_push) begin
      key_state_r <= key_state_nxt;
      tick_r      <= tick_nxt;
      held_r      <= held_nxt;
      dash_rep_r  <= dash_rep_nxt;
    end
  end

  // A dash can only be pending while the key is down
  a_dash_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    dash_rep_r |-> key_state_r)
    else $error("dash flag set with key released");

  // A stored held length only lives through a release
  a_held_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != '0) |-> !key_state_r)
    else $error("held length kept while key pressed");

endmodule

@@ rtl/mkd_queue.sv @@
module mkd_queue import mkd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  mkd_evt_t push_data,
  output logic     full,
  input  logic     pop,
  output mkd_evt_t pop_data,
  output logic     empty
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  mkd_evt_t           mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full     = (count_r == CNT_W'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Neither overrun nor underrun the buffer
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && push && !pop) && !(pop && empty))
    else $error("queue overrun or underrun");

endmodule

@@ rtl/mkd_back.sv @@
module mkd_back import mkd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  mkd_evt_t q_data,
  output logic     q_pop,
  mkd_out_if.source out_ch
);

  logic [2:0] sym_cnt_r, sym_cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       out_valid_r;
  logic [1:0] ev_r, ev_nxt;
  logic       cv_r, cv_nxt;
  logic [3:0] code_r, code_nxt;
  logic       inv_r, inv_nxt;

  logic [2:0]  cnt_a;
  logic [3:0]  weight;
  logic [6:0]  prod;
  logic [8:0]  sum_wide;
  logic [7:0]  sum_a;
  mkd_match_t  match;

  // Pop when the output register is free or being drained
  assign q_pop = !q_empty && (!out_valid_r || out_ch.ready);

  // Add the symbol, then close the character on a gap
  always_comb begin
    weight   = q_data.dash ? W_DASH : W_DOT;
    cnt_a    = sym_cnt_r;
    if ((q_data.dot || q_data.dash) && sym_cnt_r < SYM_SAT) begin
      cnt_a = sym_cnt_r + 1'b1;
    end
    prod     = (q_data.dot || q_data.dash) ? (7'(weight) * 7'(cnt_a)) : 7'd0;
    sum_wide = {1'b0, sum_r} + {2'b00, prod};
    sum_a    = sum_wide[8] ? 8'hFF : sum_wide[7:0];
    match    = mkd_lookup(sum_a);

    ev_nxt      = q_data.dash ? EV_DASH : (q_data.dot ? EV_DOT : EV_NONE);
    cv_nxt      = 1'b0;
    code_nxt    = 4'd0;
    inv_nxt     = 1'b0;
    sym_cnt_nxt = cnt_a;
    sum_nxt     = sum_a;
    if (q_data.gap && cnt_a != 3'd0) begin
      cv_nxt      = 1'b1;
      if (match.found && cnt_a <= SYM_MAX) begin
        code_nxt = match.code;
      end else begin
        inv_nxt  = 1'b1;
      end
      sym_cnt_nxt = 3'd0;
      sum_nxt     = 8'd0;
    end
  end

  // Hold character state and the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_cnt_r   <= 3'd0;
      sum_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        sym_cnt_r   <= sym_cnt_nxt;
        sum_r       <= sum_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ev_r   <= ev_nxt;
      cv_r   <= cv_nxt;
      code_r <= code_nxt;
      inv_r  <= inv_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.symbol_event = ev_r;
  assign out_ch.char_valid   = cv_r;
  assign out_ch.char_code    = code_r;
  assign out_ch.char_invalid = inv_r;

  // Symbol count never passes its saturation point
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    sym_cnt_r <= SYM_SAT)
    else $error("symbol count above saturation");

  // An invalid or absent character carries code zero
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (inv_r || !cv_r)) |-> (code_r == 4'd0))
    else $error("char code set on invalid character");

  // Empty character state after a closed character
  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.gap) |=> (sym_cnt_r == 3'd0 && sum_r == 8'd0))
    else $error("character state not cleared by gap");

endmodule

@@ rtl/morse_keying_decoder_top.sv @@
// Morse keying decoder.
// in_ch carries one sampled key level (key_down) per word, one word per tick.
// out_ch returns exactly one word per input word, in order: symbol_event
// (none, dot, dash), and on a character end char_valid with char_code
// (A,B,C,D,S,E,N,T,1..5) or char_invalid.
// Timing thresholds dot_min_ticks, dash_ticks and gap_ticks sit at byte
// addresses 0, 4 and 8 of the cfg_ register port; write them while idle.
// An accepted word passes through the queue and then the result register.
// Throughput: one word per cycle while the receiver does not stall. The front
// timing unit classifies each word in the cycle it is accepted; the back unit
// takes it from the queue, updates the character and registers the result.
// A two-entry queue sits between front and back, and the result register
// holds a word while the receiver stalls; input is refused only once the
// queue fills. Reset clears the key timing, the character and both buffers
// and loads the threshold defaults; no warm-up is needed.
module morse_keying_decoder_top import mkd_pkg::*; #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mkd_in_if.sink      in_ch,
  mkd_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] dot_min_r;
  logic [15:0] dash_r;
  logic [15:0] gap_r;
  logic        cfg_wr;
  logic        q_push, q_full, q_pop, q_empty;
  mkd_evt_t    q_wdata, q_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Write threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_min_r <= DOT_MIN_RESET;
      dash_r    <= DASH_RESET;
      gap_r     <= GAP_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_DOT_MIN: dot_min_r <= cfg_pwdata[15:0];
        REG_DASH:    dash_r    <= cfg_pwdata[15:0];
        REG_GAP:     gap_r     <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back threshold registers
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_DOT_MIN: cfg_prdata = {16'd0, dot_min_r};
      REG_DASH:    cfg_prdata = {16'd0, dash_r};
      REG_GAP:     cfg_prdata = {16'd0, gap_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  mkd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .dot_min_ticks(dot_min_r),
    .dash_ticks   (dash_r),
    .gap_ticks    (gap_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  mkd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty)
  );

  mkd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_empty(q_empty),
    .q_data (q_rdata),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
